@@ sv/k_way_posting_merge_unit_macros.svh @@
// assertion macros for the k-way posting merge unit
// used by the top level only; expects i_clk and i_rst_n in scope
`ifndef K_WAY_POSTING_MERGE_UNIT_MACROS_SVH
`define K_WAY_POSTING_MERGE_UNIT_MACROS_SVH

// consequent checked in the same cycle
`define KWPM_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define KWPM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/kwpm_pkg.sv @@
// shared constants and types for the k-way posting merge unit
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package kwpm_pkg;

    localparam int NUM_SOURCES = 8;
    localparam int SRC_W       = 3;
    localparam int IDX_W       = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
    localparam int CNT_W       = 4;
    localparam int WORD_W      = 24;
    localparam int DOC_W       = 32;
    localparam int FREQ_W      = 16;
    // the 3-bit source field reaches no more than eight sources
    localparam int MAX_ACT     = (NUM_SOURCES < 8) ? NUM_SOURCES : 8;
    localparam int TREE_LEAVES = 2 ** IDX_W;

    localparam logic [CNT_W-1:0] CFG_RESET = CNT_W'(8);

    localparam logic FUNC_ENTRY = 1'b0;
    localparam logic FUNC_END   = 1'b1;

    typedef struct packed {
        logic              en;
        logic              func;
        logic [IDX_W-1:0]  idx;
        logic [WORD_W-1:0] word;
        logic [DOC_W-1:0]  doc;
        logic [FREQ_W-1:0] freq;
    } t_head_wr;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
    } t_head_clr;

    typedef struct packed {
        logic             ready;
        logic             found;
        logic [IDX_W-1:0] idx;
    } t_sel;

endpackage

@@ sv/k_way_posting_merge_unit.sv @@
// k-way posting merge unit, top level
// depends on kwpm_pkg, kwpm_head_store, kwpm_min_select and the macros header
`timescale 1ns / 1ps
`include "k_way_posting_merge_unit_macros.svh"

// Merges up to eight sorted posting streams into one stream ordered by word id.
// Input channel (i_in_valid / o_in_stall): each request either delivers the next
// entry of a source (func 0) or marks that source as ended (func 1).
// Output channel (o_out_valid / i_out_stall): the smallest held head, lower source
// on a tie, with a new-word flag and the source that must send its next entry.
// i_cfg_we / i_cfg_data set the number of sources in use; write only when idle.
// An accepted request sits in an input register until it can fire; the head
// update, the readiness check and the comparator tree then all run in that
// cycle, and any result is loaded into the output register, from which the
// receiver takes it.
// A request is taken every cycle while the output register is empty or drained;
// at most one result comes from each request. With the output stalled and full,
// one more request is held in the input register and then o_in_stall rises.
// Reset (synchronous, active low) clears all heads, ended marks and the
// last-word history and sets the source count to eight.
module k_way_posting_merge_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [kwpm_pkg::CNT_W-1:0]    i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_func,
    input  logic [kwpm_pkg::SRC_W-1:0]    i_source,
    input  logic [kwpm_pkg::WORD_W-1:0]   i_word_id,
    input  logic [kwpm_pkg::DOC_W-1:0]    i_doc_id,
    input  logic [kwpm_pkg::FREQ_W-1:0]   i_frequency,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [kwpm_pkg::WORD_W-1:0]   o_out_word,
    output logic [kwpm_pkg::DOC_W-1:0]    o_out_doc,
    output logic [kwpm_pkg::FREQ_W-1:0]   o_out_freq,
    output logic                          o_new_word,
    output logic [kwpm_pkg::SRC_W-1:0]    o_refill_source
);
    import kwpm_pkg::*;

    logic [CNT_W-1:0]       r_cfg_count;
    logic [CNT_W-1:0]       w_eff;

    logic                   r_in_valid;
    logic                   n_in_valid;
    logic                   r_in_func;
    logic [SRC_W-1:0]       r_in_source;
    logic [WORD_W-1:0]      r_in_word;
    logic [DOC_W-1:0]       r_in_doc;
    logic [FREQ_W-1:0]      r_in_freq;

    logic                   r_out_valid;
    logic                   n_out_valid;
    logic [WORD_W-1:0]      r_out_word;
    logic [DOC_W-1:0]       r_out_doc;
    logic [FREQ_W-1:0]      r_out_freq;
    logic                   r_out_new;
    logic [SRC_W-1:0]       r_out_refill;

    logic [WORD_W-1:0]      r_last_word;
    logic                   r_have_last;

    logic                   w_accept;
    logic                   w_fire;
    logic                   w_emit;
    t_head_wr               w_wr;
    t_head_clr              w_clr;
    t_sel                   w_sel;

    logic [NUM_SOURCES-1:0] w_head_valid;
    logic [NUM_SOURCES-1:0] w_view_valid;
    logic [NUM_SOURCES-1:0] w_view_ended;
    logic [WORD_W-1:0]      w_view_word [NUM_SOURCES];
    logic [DOC_W-1:0]       w_view_doc  [NUM_SOURCES];
    logic [FREQ_W-1:0]      w_view_freq [NUM_SOURCES];
    logic [WORD_W-1:0]      w_best_word;

    // counts beyond the reachable sources clamp down
    assign w_eff = (r_cfg_count > CNT_W'(MAX_ACT)) ? CNT_W'(MAX_ACT) : r_cfg_count;

    assign w_fire     = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_fire;
    assign w_accept   = i_in_valid && !o_in_stall;

    always_comb begin
        w_wr.en   = w_fire && (CNT_W'(r_in_source) < w_eff);
        w_wr.func = r_in_func;
        w_wr.idx  = IDX_W'(r_in_source);
        w_wr.word = r_in_word;
        w_wr.doc  = r_in_doc;
        w_wr.freq = r_in_freq;
    end

    assign w_emit    = w_fire && w_sel.ready && w_sel.found;
    assign w_clr.en  = w_emit;
    assign w_clr.idx = w_sel.idx;

    kwpm_head_store u_heads (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_wr         (w_wr),
        .i_clr        (w_clr),
        .o_head_valid (w_head_valid),
        .o_view_valid (w_view_valid),
        .o_view_ended (w_view_ended),
        .o_view_word  (w_view_word),
        .o_view_doc   (w_view_doc),
        .o_view_freq  (w_view_freq)
    );

    kwpm_min_select u_select (
        .i_valid (w_view_valid),
        .i_ended (w_view_ended),
        .i_word  (w_view_word),
        .i_count (w_eff),
        .o_sel   (w_sel)
    );

    assign w_best_word = w_view_word[w_sel.idx];

    always_comb begin
        n_in_valid = r_in_valid;
        if (w_accept) begin
            n_in_valid = 1'b1;
        end else if (w_fire) begin
            n_in_valid = 1'b0;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_emit) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_count <= CFG_RESET;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_last_word <= '0;
            r_have_last <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cfg_count <= i_cfg_data;
            end
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            if (w_emit) begin
                r_last_word <= w_best_word;
                r_have_last <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_func   <= i_func;
            r_in_source <= i_source;
            r_in_word   <= i_word_id;
            r_in_doc    <= i_doc_id;
            r_in_freq   <= i_frequency;
        end
        if (w_emit) begin
            r_out_word   <= w_best_word;
            r_out_doc    <= w_view_doc[w_sel.idx];
            r_out_freq   <= w_view_freq[w_sel.idx];
            r_out_new    <= !r_have_last || (w_best_word != r_last_word);
            r_out_refill <= SRC_W'(w_sel.idx);
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_word      = r_out_word;
    assign o_out_doc       = r_out_doc;
    assign o_out_freq      = r_out_freq;
    assign o_new_word      = r_out_new;
    assign o_refill_source = r_out_refill;

    `KWPM_ASSERT_NEXT(a_emit_loads_result, w_emit, o_out_valid, "emitted head not presented")
    `KWPM_ASSERT_NEXT(a_head_cleared, w_emit, !w_head_valid[$past(w_sel.idx)], "head not cleared")
    `KWPM_ASSERT_SAME(a_last_word, o_out_valid, o_out_word == r_last_word, "bad history")
    `KWPM_ASSERT_SAME(a_stall_when_held, o_in_stall, r_in_valid, "stall without a held request")

endmodule

@@ sv/kwpm_head_store.sv @@
// per-source head registers with valid and ended flags
// depends on kwpm_pkg; presents the heads with the current request applied
`timescale 1ns / 1ps

module kwpm_head_store (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  kwpm_pkg::t_head_wr                i_wr,
    input  kwpm_pkg::t_head_clr               i_clr,
    output logic [kwpm_pkg::NUM_SOURCES-1:0]  o_head_valid,
    output logic [kwpm_pkg::NUM_SOURCES-1:0]  o_view_valid,
    output logic [kwpm_pkg::NUM_SOURCES-1:0]  o_view_ended,
    output logic [kwpm_pkg::WORD_W-1:0]       o_view_word [kwpm_pkg::NUM_SOURCES],
    output logic [kwpm_pkg::DOC_W-1:0]        o_view_doc  [kwpm_pkg::NUM_SOURCES],
    output logic [kwpm_pkg::FREQ_W-1:0]       o_view_freq [kwpm_pkg::NUM_SOURCES]
);
    import kwpm_pkg::*;

    logic [NUM_SOURCES-1:0] r_valid;
    logic [NUM_SOURCES-1:0] r_ended;
    logic [NUM_SOURCES-1:0] n_valid;
    logic [WORD_W-1:0]      r_word [NUM_SOURCES];
    logic [DOC_W-1:0]       r_doc  [NUM_SOURCES];
    logic [FREQ_W-1:0]      r_freq [NUM_SOURCES];

    always_comb begin
        o_view_valid = r_valid;
        o_view_ended = r_ended;
        o_view_word  = r_word;
        o_view_doc   = r_doc;
        o_view_freq  = r_freq;
        if (i_wr.en) begin
            case (i_wr.func)
                FUNC_ENTRY: begin
                    // an entry for a source that still holds a head is dropped
                    if (!r_valid[i_wr.idx]) begin
                        o_view_valid[i_wr.idx] = 1'b1;
                        o_view_word[i_wr.idx]  = i_wr.word;
                        o_view_doc[i_wr.idx]   = i_wr.doc;
                        o_view_freq[i_wr.idx]  = i_wr.freq;
                    end
                end
                FUNC_END: begin
                    o_view_ended[i_wr.idx] = 1'b1;
                end
                default: begin
                    o_view_valid = r_valid;
                end
            endcase
        end
    end

    always_comb begin
        n_valid = o_view_valid;
        if (i_clr.en) begin
            n_valid[i_clr.idx] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_ended <= '0;
        end else begin
            r_valid <= n_valid;
            r_ended <= o_view_ended;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= o_view_word;
        r_doc  <= o_view_doc;
        r_freq <= o_view_freq;
    end

    assign o_head_valid = r_valid;

endmodule

@@ sv/kwpm_min_select.sv @@
// readiness check and smallest-head comparator tree
// depends on kwpm_pkg; purely combinational, ties go to the lower source
`timescale 1ns / 1ps

module kwpm_min_select (
    input  logic [kwpm_pkg::NUM_SOURCES-1:0] i_valid,
    input  logic [kwpm_pkg::NUM_SOURCES-1:0] i_ended,
    input  logic [kwpm_pkg::WORD_W-1:0]      i_word [kwpm_pkg::NUM_SOURCES],
    input  logic [kwpm_pkg::CNT_W-1:0]       i_count,
    output kwpm_pkg::t_sel                   o_sel
);
    import kwpm_pkg::*;

    localparam int NODES = 2 * TREE_LEAVES - 1;

    logic [NUM_SOURCES-1:0] w_part;
    logic                   w_nv    [NODES];
    logic [WORD_W-1:0]      w_nword [NODES];
    logic [IDX_W-1:0]       w_nidx  [NODES];

    always_comb begin
        for (int i = 0; i < NUM_SOURCES; i++) begin
            w_part[i] = (i < MAX_ACT) && (CNT_W'(i) < i_count);
        end
    end

    // leaves sit at the bottom of a heap-ordered tree, lowest source leftmost
    for (genvar g = 0; g < TREE_LEAVES; g++) begin : g_leaf
        if (g < NUM_SOURCES) begin : g_used
            assign w_nv[TREE_LEAVES-1+g]    = i_valid[g] && w_part[g];
            assign w_nword[TREE_LEAVES-1+g] = i_word[g];
        end else begin : g_pad
            assign w_nv[TREE_LEAVES-1+g]    = 1'b0;
            assign w_nword[TREE_LEAVES-1+g] = '0;
        end
        assign w_nidx[TREE_LEAVES-1+g] = IDX_W'(g);
    end

    for (genvar k = 0; k < TREE_LEAVES - 1; k++) begin : g_node
        logic w_pick_l;
        assign w_pick_l = w_nv[2*k+1]
                       && (!w_nv[2*k+2] || (w_nword[2*k+1] <= w_nword[2*k+2]));
        assign w_nv[k]    = w_nv[2*k+1] || w_nv[2*k+2];
        assign w_nword[k] = w_pick_l ? w_nword[2*k+1] : w_nword[2*k+2];
        assign w_nidx[k]  = w_pick_l ? w_nidx[2*k+1] : w_nidx[2*k+2];
    end

    assign o_sel.ready = &(~w_part | i_valid | i_ended);
    assign o_sel.found = w_nv[0];
    assign o_sel.idx   = w_nidx[0];

endmodule

@@ tb/tb.sv @@
// self-checking testbench for k_way_posting_merge_unit: directed table, then random phases
// depends on kwpm_pkg and the merge unit rtl; results checked against an in-bench merge predictor
`timescale 1ns / 1ps

module tb;
    import kwpm_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 4;
    localparam int TAIL_CYCLES  = 8;
    localparam int PHASES       = 7;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic [DOC_W-1:0]  doc;
        logic [FREQ_W-1:0] freq;
        logic              new_word;
        logic [SRC_W-1:0]  refill;
    } t_posting;

    typedef enum logic {ROW_REQ, ROW_CFG} t_row_kind;
    typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_HIT} t_chk;

    typedef struct {
        t_row_kind         kind;
        logic [CNT_W-1:0]  count;
        logic              func;
        logic [SRC_W-1:0]  src;
        logic [WORD_W-1:0] word;
        logic [DOC_W-1:0]  doc;
        logic [FREQ_W-1:0] freq;
        t_chk              how;
        t_posting          want;
    } t_plan_row;

    localparam t_posting NO_POST = '0;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [CNT_W-1:0]  i_cfg_data;
    logic              i_in_valid;
    logic              o_in_stall;
    logic              i_func;
    logic [SRC_W-1:0]  i_source;
    logic [WORD_W-1:0] i_word_id;
    logic [DOC_W-1:0]  i_doc_id;
    logic [FREQ_W-1:0] i_frequency;
    logic              o_out_valid;
    logic              i_out_stall;
    logic [WORD_W-1:0] o_out_word;
    logic [DOC_W-1:0]  o_out_doc;
    logic [FREQ_W-1:0] o_out_freq;
    logic              o_new_word;
    logic [SRC_W-1:0]  o_refill_source;

    k_way_posting_merge_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_func          (i_func),
        .i_source        (i_source),
        .i_word_id       (i_word_id),
        .i_doc_id        (i_doc_id),
        .i_frequency     (i_frequency),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_out_word      (o_out_word),
        .o_out_doc       (o_out_doc),
        .o_out_freq      (o_out_freq),
        .o_new_word      (o_new_word),
        .o_refill_source (o_refill_source)
    );

    // merge predictor state
    bit                head_held [NUM_SOURCES];
    bit                src_done  [NUM_SOURCES];
    logic [WORD_W-1:0] head_w    [NUM_SOURCES];
    logic [DOC_W-1:0]  head_d    [NUM_SOURCES];
    logic [FREQ_W-1:0] head_f    [NUM_SOURCES];
    logic [WORD_W-1:0] prev_word = '0;
    bit                prev_seen = 1'b0;
    int unsigned       src_count = 32'(CFG_RESET);

    t_posting          due_postings [$];
    t_plan_row         plan [$];
    logic [WORD_W-1:0] cursor [8];
    bit                no_idle = 1'b0;
    int unsigned       errors = 0;
    int unsigned       req_count = 0;
    int unsigned       end_count = 0;
    int unsigned       setting_count = 0;
    int unsigned       results_checked = 0;
    int unsigned       cycle_count = 0;
    t_posting          seen;
    t_posting          want;

    function automatic int unsigned live_count();
        return (src_count < MAX_ACT) ? src_count : MAX_ACT;
    endfunction

    function automatic void queue_post(input t_posting p);
        due_postings = {due_postings, p};
    endfunction

    function automatic void add_row(input t_plan_row r);
        plan = {plan, r};
    endfunction

    // one request through the merge; returns 1 when a posting comes out
    function automatic bit predict_merge(input logic func, input logic [SRC_W-1:0] src,
                                         input logic [WORD_W-1:0] word,
                                         input logic [DOC_W-1:0] doc,
                                         input logic [FREQ_W-1:0] freq,
                                         output t_posting res, output bit effect);
        int unsigned n;
        int unsigned best;
        bit          ready;
        bit          found;
        n      = live_count();
        best   = 0;
        ready  = 1'b1;
        found  = 1'b0;
        effect = 1'b0;
        res    = NO_POST;
        if (src < n) begin
            if (func == FUNC_ENTRY) begin
                if (!head_held[src]) begin
                    head_held[src] = 1'b1;
                    head_w[src]    = word;
                    head_d[src]    = doc;
                    head_f[src]    = freq;
                    effect         = 1'b1;
                end
            end else begin
                src_done[src] = 1'b1;
                effect        = 1'b1;
            end
        end
        for (int unsigned i = 0; i < n; i++) begin
            if (!head_held[i] && !src_done[i])
                ready = 1'b0;
            if (head_held[i] && (!found || head_w[i] < head_w[best])) begin
                best  = i;
                found = 1'b1;
            end
        end
        if (!ready || !found)
            return 1'b0;
        res.word     = head_w[best];
        res.doc      = head_d[best];
        res.freq     = head_f[best];
        res.new_word = !prev_seen || (head_w[best] != prev_word);
        res.refill   = SRC_W'(best);
        prev_word    = head_w[best];
        prev_seen    = 1'b1;
        head_held[best] = 1'b0;
        return 1'b1;
    endfunction

    function automatic t_posting mk_post(input logic [WORD_W-1:0] w, input logic [DOC_W-1:0] d,
                                         input logic [FREQ_W-1:0] f, input logic nw,
                                         input logic [SRC_W-1:0] rs);
        t_posting p;
        p.word     = w;
        p.doc      = d;
        p.freq     = f;
        p.new_word = nw;
        p.refill   = rs;
        return p;
    endfunction

    function automatic t_plan_row mk_req(input logic func, input logic [SRC_W-1:0] src,
                                         input logic [WORD_W-1:0] w, input logic [DOC_W-1:0] d,
                                         input logic [FREQ_W-1:0] f, input t_chk how,
                                         input t_posting p);
        t_plan_row r;
        r.kind  = ROW_REQ;
        r.count = '0;
        r.func  = func;
        r.src   = src;
        r.word  = w;
        r.doc   = d;
        r.freq  = f;
        r.how   = how;
        r.want  = p;
        return r;
    endfunction

    function automatic t_plan_row mk_cfg(input logic [CNT_W-1:0] v);
        t_plan_row r;
        r       = mk_req(FUNC_ENTRY, '0, '0, '0, '0, CHK_NONE, NO_POST);
        r.kind  = ROW_CFG;
        r.count = v;
        return r;
    endfunction

    function automatic void note_error(input string msg);
        errors++;
        if (errors <= 10)
            $display("tb: mismatch: %s", msg);
    endfunction

    // drive one request, wait for it to be taken, then log what it should produce
    task automatic issue(input logic func, input logic [SRC_W-1:0] src,
                         input logic [WORD_W-1:0] word, input logic [DOC_W-1:0] doc,
                         input logic [FREQ_W-1:0] freq, input t_chk how,
                         input t_posting typed, output bit effect);
        int unsigned gap;
        bit          hit;
        t_posting    res;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_func      <= func;
        i_source    <= src;
        i_word_id   <= word;
        i_doc_id    <= doc;
        i_frequency <= freq;
        do @(posedge i_clk); while (!(i_in_valid && !o_in_stall));
        req_count++;
        if (func == FUNC_END)
            end_count++;
        hit = predict_merge(func, src, word, doc, freq, res, effect);
        case (how)
            CHK_MODEL: if (hit) queue_post(res);
            CHK_HIT:   queue_post(typed);
            default: ;
        endcase
    endtask

    task automatic hold_until_empty();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (due_postings.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CNT_W-1:0] v);
        hold_until_empty();
        // a request with no result may still sit in the input register
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        src_count  = 32'(v);
        setting_count++;
    endtask

    // mostly refills of empty sources with non-decreasing words, some noise
    task automatic random_req(input bit with_ends, output bit effect);
        int unsigned       n;
        int unsigned       roll;
        int unsigned       open_src [$];
        logic              func;
        logic [SRC_W-1:0]  src;
        logic [WORD_W-1:0] word;
        n    = live_count();
        roll = $urandom_range(0, 99);
        func = FUNC_ENTRY;
        src  = SRC_W'($urandom_range(0, 7));
        word = WORD_W'($urandom);
        for (int unsigned i = 0; i < n; i++)
            if (!head_held[i])
                open_src = {open_src, i};
        if (with_ends && n != 0 && roll < 5) begin
            func = FUNC_END;
            src  = SRC_W'($urandom_range(0, n - 1));
        end else if (roll < 85 && open_src.size() != 0) begin
            src         = SRC_W'(open_src[$urandom_range(0, open_src.size() - 1)]);
            cursor[src] = WORD_W'(cursor[src] + $urandom_range(0, 2));
            word        = cursor[src];
        end else if (src >= n && roll >= 95) begin
            func = FUNC_END;
        end
        issue(func, src, word, $urandom, FREQ_W'($urandom), CHK_MODEL, NO_POST, effect);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: timeout after %0d cycles", cycle_count);
            $display("tb: done, errors");
            $finish;
        end
    end

    // output side randomly stalls ahead of each result, except in the no-idle phases
    initial begin : out_stall_gen
        int unsigned hold;
        i_out_stall = 1'b0;
        while (i_rst_n !== 1'b1)
            @(posedge i_clk);
        forever begin
            hold = no_idle ? 0 : $urandom_range(0, 6);
            if (hold != 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_out_valid && !i_out_stall));
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            seen = mk_post(o_out_word, o_out_doc, o_out_freq, o_new_word, o_refill_source);
            if (due_postings.size() == 0) begin
                note_error($sformatf("unexpected result word %h doc %h freq %h new %b refill %0d",
                                     seen.word, seen.doc, seen.freq, seen.new_word, seen.refill));
            end else begin
                want = due_postings.pop_front();
                results_checked++;
                if (seen.word !== want.word || seen.doc !== want.doc || seen.freq !== want.freq
                        || seen.new_word !== want.new_word || seen.refill !== want.refill)
                    note_error($sformatf({"result %0d: want %h/%h/%h new %b refill %0d,",
                                          " got %h/%h/%h new %b refill %0d"}, results_checked,
                                         want.word, want.doc, want.freq, want.new_word,
                                         want.refill, seen.word, seen.doc, seen.freq,
                                         seen.new_word, seen.refill));
            end
        end
    end

    initial begin : stimulus
        int unsigned phase_count [PHASES];
        int unsigned phase_quota [PHASES];
        int unsigned k;
        bit          effect;
        phase_count = '{8, 3, 1, 15, 0, 5, 8};
        phase_quota = '{400, 200, 100, 250, 20, 200, 280};
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_func      = FUNC_ENTRY;
        i_source    = '0;
        i_word_id   = '0;
        i_doc_id    = '0;
        i_frequency = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // first request after reset, all eight sources in use
        add_row(mk_req(FUNC_ENTRY, 3'd7, 24'hFFFFFF, 32'hFFFFFFFF, 16'hFFFF, CHK_NONE,
                       NO_POST));
        add_row(mk_cfg(4'd2));
        add_row(mk_req(FUNC_ENTRY, 3'd0, 24'd10, 32'd100, 16'd1, CHK_NONE, NO_POST));
        // end while a head is held: the head still merges
        add_row(mk_req(FUNC_END, 3'd0, '0, '0, '0, CHK_NONE, NO_POST));
        add_row(mk_req(FUNC_ENTRY, 3'd1, 24'd20, 32'd200, 16'd2, CHK_HIT,
                       mk_post(24'd10, 32'd100, 16'd1, 1'b1, 3'd0)));
        // inactive source ignored, but the pending emission goes out on it
        add_row(mk_req(FUNC_ENTRY, 3'd7, 24'd1, 32'd1, 16'd1, CHK_HIT,
                       mk_post(24'd20, 32'd200, 16'd2, 1'b1, 3'd1)));
        add_row(mk_req(FUNC_ENTRY, 3'd1, '0, '0, '0, CHK_HIT,
                       mk_post('0, '0, '0, 1'b1, 3'd1)));
        add_row(mk_req(FUNC_ENTRY, 3'd1, '0, 32'd5, 16'd6, CHK_HIT,
                       mk_post('0, 32'd5, 16'd6, 1'b0, 3'd1)));
        add_row(mk_req(FUNC_ENTRY, 3'd1, 24'hFFFFFF, 32'hFFFFFFFF, 16'hFFFF, CHK_HIT,
                       mk_post(24'hFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 1'b1, 3'd1)));
        // merge finished, then an entry after the end is still taken
        add_row(mk_req(FUNC_END, 3'd1, '0, '0, '0, CHK_NONE, NO_POST));
        add_row(mk_req(FUNC_ENTRY, 3'd0, 24'h123456, 32'hA5A5A5A5, 16'h5A5A, CHK_HIT,
                       mk_post(24'h123456, 32'hA5A5A5A5, 16'h5A5A, 1'b1, 3'd0)));
        add_row(mk_cfg(4'd0));
        add_row(mk_req(FUNC_ENTRY, 3'd0, 24'd7, 32'd7, 16'd7, CHK_NONE, NO_POST));
        add_row(mk_req(FUNC_END, 3'd2, '0, '0, '0, CHK_NONE, NO_POST));
        // count above eight clamps to eight
        add_row(mk_cfg(4'd15));
        // source 7 still holds its old head, so this entry is dropped
        add_row(mk_req(FUNC_ENTRY, 3'd7, 24'd3, 32'd3, 16'd3, CHK_NONE, NO_POST));
        add_row(mk_req(FUNC_ENTRY, 3'd2, 24'h800000, 32'h80000000, 16'h8000, CHK_MODEL,
                       NO_POST));
        add_row(mk_req(FUNC_ENTRY, 3'd3, 24'h000400, 32'd1, 16'd1, CHK_MODEL, NO_POST));
        add_row(mk_req(FUNC_ENTRY, 3'd4, 24'h000400, 32'd2, 16'd2, CHK_MODEL, NO_POST));
        add_row(mk_req(FUNC_ENTRY, 3'd5, 24'h000001, 32'h55555555, 16'h5555, CHK_MODEL,
                       NO_POST));
        add_row(mk_req(FUNC_ENTRY, 3'd6, 24'h7FFFFF, 32'h0, 16'hFFFF, CHK_HIT,
                       mk_post(24'h000001, 32'h55555555, 16'h5555, 1'b1, 3'd5)));
        // equal words: lower source wins
        add_row(mk_req(FUNC_END, 3'd5, '0, '0, '0, CHK_HIT,
                       mk_post(24'h000400, 32'd1, 16'd1, 1'b1, 3'd3)));
        add_row(mk_req(FUNC_ENTRY, 3'd3, 24'h000400, 32'hFFFFFFFF, 16'h0, CHK_HIT,
                       mk_post(24'h000400, 32'hFFFFFFFF, 16'h0, 1'b0, 3'd3)));
        add_row(mk_cfg(4'd1));
        add_row(mk_req(FUNC_ENTRY, 3'd0, 24'hFFFFFF, 32'd9, 16'd8, CHK_HIT,
                       mk_post(24'hFFFFFF, 32'd9, 16'd8, 1'b1, 3'd0)));
        add_row(mk_req(FUNC_ENTRY, 3'd3, 24'd1, 32'd0, 16'd0, CHK_MODEL, NO_POST));

        foreach (plan[r]) begin
            if (plan[r].kind == ROW_CFG)
                cfg_write(plan[r].count);
            else
                issue(plan[r].func, plan[r].src, plan[r].word, plan[r].doc, plan[r].freq,
                      plan[r].how, plan[r].want, effect);
        end

        for (int p = 0; p < PHASES; p++) begin
            cfg_write(CNT_W'(phase_count[p]));
            no_idle = (p == 1 || p == 5);
            foreach (cursor[i])
                cursor[i] = WORD_W'($urandom_range(0, 24'hFFF000));
            k = 0;
            while (k < phase_quota[p]) begin
                if (p == 0 && k == phase_quota[p] / 2)
                    hold_until_empty();
                random_req(p == PHASES - 1, effect);
                // requests that change nothing do not count, unless nothing can
                if (effect || live_count() == 0)
                    k++;
            end
        end
        no_idle = 1'b0;

        hold_until_empty();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("tb: %0d requests sent (%0d end marks), %0d merged postings checked",
                 req_count, end_count, results_checked);
        $display("tb: %0d source-count settings, %0d mismatches", setting_count, errors);
        if (errors == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

@@ k_way_posting_merge_unit.f @@
+incdir+sv
sv/kwpm_pkg.sv
sv/kwpm_head_store.sv
sv/kwpm_min_select.sv
sv/k_way_posting_merge_unit.sv
tb/tb.sv
